// File: hdl/plgp_pkg.sv
// Shared types and constants for the pallet layer grid placer.
// Used by the divider, controller, datapath and top level; depends on nothing.
package plgp_pkg;

  // Largest number of boxes allowed along one pallet axis (range 1 to 8).
  localparam int MAX_PER_AXIS = 8;

  // Position tables and loop counters are sized for the largest allowed axis.
  localparam int IDX_W     = 3;
  localparam int POS_DEPTH = 1 << IDX_W;

  localparam int DIM_W   = 12;
  localparam int TYPE_W  = 16;
  localparam int COUNT_W = 24;

  // Shared divider: 16-bit dividend, 12-bit divisor, two quotient bits a cycle.
  localparam int DVD_W     = 16;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 104;
  localparam int M_TUSER_W = 2;

  localparam logic [DIM_W-1:0] PALLET_LENGTH_RST = 12'd1200;
  localparam logic [DIM_W-1:0] PALLET_WIDTH_RST  = 12'd800;

  typedef enum logic {
    REG_PALLET_LENGTH = 1'b0,
    REG_PALLET_WIDTH  = 1'b1
  } reg_idx_t;

  // Which group of divisions the datapath is feeding to the divider.
  typedef enum logic [1:0] {
    PH_FIT  = 2'd0,
    PH_POSX = 2'd1,
    PH_POSY = 2'd2
  } phase_t;

  // Fit divisions, selected by the low bits of the loop counter.
  localparam logic [1:0] FIT_NXO = 2'd0;
  localparam logic [1:0] FIT_NYO = 2'd1;
  localparam logic [1:0] FIT_NXR = 2'd2;
  localparam logic [1:0] FIT_NYR = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT_START,
    ST_FIT_WAIT,
    ST_MUL_O,
    ST_MUL_R,
    ST_CHOOSE,
    ST_DECIDE,
    ST_PX_START,
    ST_PX_WAIT,
    ST_PY_START,
    ST_PY_WAIT,
    ST_EMIT,
    ST_SPECIAL
  } state_t;

  typedef struct packed {
    logic   load_in;
    logic   clr_idx;
    logic   inc_idx;
    logic   div_start;
    phase_t phase;
    logic   mul_orig;
    logic   mul_rot;
    logic   choose;
    logic   emit_load;
    logic   special_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic idx_last;
    logic empty;
    logic overflow;
    logic out_free;
    logic emit_last;
  } ctrl_stat_t;

endpackage

// File: hdl/pallet_layer_grid_placer_top.sv
// Order of work: 4 fit divisions, then the count, compare and decision steps;
// a special result then goes to the output register once that register is free.
// A placed layer adds one division per position on each axis (up to 16), then one
// placement per cycle while the output is taken.
// Throughput: one box type at a time, paced by the shared divider.
// Reset (rst, synchronous, active high) clears control and loads a 1200 by 800 pallet.
module pallet_layer_grid_placer_top (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel; index 0 pallet_length, 1 pallet_width.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  plgp_pkg::reg_idx_t              cfg_index,
  input  logic [plgp_pkg::DIM_W-1:0]      cfg_data,
  // Input box types.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // s_axis_tdata, lowest bit up: box_length[11:0], box_width[23:12],
  // box_height[35:24], type_index[51:36], zero padding[55:52].
  input  logic [plgp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // Output placements.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // m_axis_tdata, lowest bit up: pos_x[11:0], pos_y[23:12], size_x[35:24],
  // size_y[47:36], size_z[59:48], box_type[75:60], rotated[76],
  // layer_count[100:77], zero padding[103:101].
  output logic [plgp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // m_axis_tuser, lowest bit up: empty_res[0], overflow[1].
  output logic [plgp_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  // m_axis_tlast marks the final placement of a box type.
  output logic                            m_axis_tlast
);
  import plgp_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Configuration writes are always taken; they must arrive only while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // The controller accepts a new box type only in its idle state. The final
  // placement of the previous type may still be waiting in the output
  // register at that time, so the two sides are decoupled by that register.
  plgp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // The datapath computes the fit counts for both orientations, picks the
  // better grid, tabulates the evenly spread positions on each axis and
  // streams out one placement per box, x index outer and y index inner.
  plgp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hdl/plgp_div.sv
// Iterative unsigned divider, restoring, two quotient bits per cycle.
// Depends on plgp_pkg for widths.
module plgp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [plgp_pkg::DVD_W-1:0]  dividend,
  input  logic [plgp_pkg::DIM_W-1:0]  divisor,
  output logic                        done,
  output logic [plgp_pkg::DVD_W-1:0]  quotient
);
  import plgp_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIM_W-1:0]     rem;
  logic [DIM_W-1:0]     dsr;
  logic [DVD_W-1:0]     qsh;

  logic [DIM_W:0]   trial1;
  logic [DIM_W:0]   trial2;
  logic [DIM_W-1:0] rem1;
  logic [DIM_W-1:0] rem_next;
  logic             qbit1;
  logic             qbit2;

  always_comb begin
    trial1 = {rem, qsh[DVD_W-1]};
    qbit1  = (trial1 >= {1'b0, dsr});
    rem1   = qbit1 ? DIM_W'(trial1 - {1'b0, dsr}) : trial1[DIM_W-1:0];
    trial2 = {rem1, qsh[DVD_W-2]};
    qbit2  = (trial2 >= {1'b0, dsr});
    rem_next = qbit2 ? DIM_W'(trial2 - {1'b0, dsr}) : trial2[DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      qsh <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      qsh <= {qsh[DVD_W-3:0], qbit1, qbit2};
    end
  end

  assign quotient = qsh;

endmodule

// File: hdl/plgp_ctrl.sv
// Controller state machine of the pallet layer grid placer.
// Sequences the datapath through command and status structs from plgp_pkg.
module plgp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  plgp_pkg::ctrl_stat_t   stat,
  output plgp_pkg::ctrl_cmd_t    cmd
);
  import plgp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_axis_tvalid) state_next = ST_FIT_START;
      ST_FIT_START: state_next = ST_FIT_WAIT;
      ST_FIT_WAIT:  if (stat.div_done) state_next = stat.idx_last ? ST_MUL_O : ST_FIT_START;
      ST_MUL_O:     state_next = ST_MUL_R;
      ST_MUL_R:     state_next = ST_CHOOSE;
      ST_CHOOSE:    state_next = ST_DECIDE;
      ST_DECIDE:    state_next = (stat.empty || stat.overflow) ? ST_SPECIAL : ST_PX_START;
      ST_PX_START:  state_next = ST_PX_WAIT;
      ST_PX_WAIT:   if (stat.div_done) state_next = stat.idx_last ? ST_PY_START : ST_PX_START;
      ST_PY_START:  state_next = ST_PY_WAIT;
      ST_PY_WAIT:   if (stat.div_done) state_next = stat.idx_last ? ST_EMIT : ST_PY_START;
      ST_EMIT:      if (stat.out_free && stat.emit_last) state_next = ST_IDLE;
      ST_SPECIAL:   if (stat.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.phase     = PH_FIT;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load_in   = s_axis_tvalid;
        cmd.clr_idx   = s_axis_tvalid;
      end
      ST_FIT_START: cmd.div_start = 1'b1;
      ST_FIT_WAIT:  cmd.inc_idx = stat.div_done;
      ST_MUL_O:     cmd.mul_orig = 1'b1;
      ST_MUL_R:     cmd.mul_rot = 1'b1;
      ST_CHOOSE:    cmd.choose = 1'b1;
      ST_DECIDE:    cmd.clr_idx = !(stat.empty || stat.overflow);
      ST_PX_START: begin
        cmd.phase     = PH_POSX;
        cmd.div_start = 1'b1;
      end
      ST_PX_WAIT: begin
        cmd.phase   = PH_POSX;
        cmd.inc_idx = stat.div_done;
        cmd.clr_idx = stat.div_done && stat.idx_last;
      end
      ST_PY_START: begin
        cmd.phase     = PH_POSY;
        cmd.div_start = 1'b1;
      end
      ST_PY_WAIT: begin
        cmd.phase   = PH_POSY;
        cmd.inc_idx = stat.div_done;
        cmd.clr_idx = stat.div_done && stat.idx_last;
      end
      ST_EMIT:    cmd.emit_load = stat.out_free;
      ST_SPECIAL: cmd.special_load = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hdl/plgp_datapath.sv
// Datapath of the pallet layer grid placer: registers, shared divider and
// multiplier, position tables and output register. Depends on plgp_pkg, plgp_div.
module plgp_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  plgp_pkg::reg_idx_t              cfg_index,
  input  logic [plgp_pkg::DIM_W-1:0]      cfg_data,
  input  logic [plgp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  plgp_pkg::ctrl_cmd_t             cmd,
  output plgp_pkg::ctrl_stat_t            stat,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [plgp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic [plgp_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  output logic                            m_axis_tlast
);
  import plgp_pkg::*;

  logic [DIM_W-1:0] pallet_length;
  logic [DIM_W-1:0] pallet_width;

  logic [DIM_W-1:0]  bl, bw, bh;
  logic [TYPE_W-1:0] ty;
  logic [DIM_W-1:0]  nxo, nyo, nxr, nyr;
  logic [COUNT_W-1:0] co, cr;
  logic               rot;
  logic [DIM_W-1:0]   nx, ny, sx, sy;
  logic [COUNT_W-1:0] cnt;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] ex, ey;
  logic [DIM_W-1:0] xpos [POS_DEPTH];
  logic [DIM_W-1:0] ypos [POS_DEPTH];

  logic [DVD_W-1:0] dvd;
  logic [DIM_W-1:0] dvs;
  logic             div_done;
  logic [DVD_W-1:0] quo;
  logic [DIM_W-1:0] q12;

  logic [IDX_W:0]   nxm1, nym1, nm1;
  logic [DIM_W-1:0] span;
  logic [DVD_W-2:0] pprod;
  logic [DVD_W-1:0] pnum;
  logic [DIM_W-1:0] mul_a, mul_b;

  logic               empty_flag;
  logic               ovf_flag;
  logic               out_free;
  logic               emit_last;

  logic [DIM_W-1:0]   o_pos_x, o_pos_y, o_size_x, o_size_y, o_size_z;
  logic [TYPE_W-1:0]  o_type;
  logic               o_rot;
  logic [COUNT_W-1:0] o_cnt;
  logic               o_empty, o_ovf, o_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pallet_length <= PALLET_LENGTH_RST;
      pallet_width  <= PALLET_WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PALLET_LENGTH: pallet_length <= cfg_data;
        REG_PALLET_WIDTH:  pallet_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Axis counts minus one; only meaningful once the grid fits the limit.
  assign nxm1 = nx[IDX_W:0] - (IDX_W+1)'(1);
  assign nym1 = ny[IDX_W:0] - (IDX_W+1)'(1);

  // Spread position numerator 2*i*(F-d) + N-1 for the axis being worked on.
  always_comb begin
    if (cmd.phase == PH_POSY) begin
      span = pallet_width - sy;
      nm1  = nym1;
    end else begin
      span = pallet_length - sx;
      nm1  = nxm1;
    end
    pprod = {{(DVD_W-1-IDX_W){1'b0}}, idx} * {{(DVD_W-1-DIM_W){1'b0}}, span};
    pnum  = {pprod, 1'b0} + {{(DVD_W-IDX_W-1){1'b0}}, nm1};
  end

  always_comb begin
    dvd = '0;
    dvs = '0;
    case (cmd.phase)
      PH_FIT: begin
        case (idx[1:0])
          FIT_NXO: begin dvd = {{(DVD_W-DIM_W){1'b0}}, pallet_length}; dvs = bl; end
          FIT_NYO: begin dvd = {{(DVD_W-DIM_W){1'b0}}, pallet_width};  dvs = bw; end
          FIT_NXR: begin dvd = {{(DVD_W-DIM_W){1'b0}}, pallet_length}; dvs = bw; end
          default: begin dvd = {{(DVD_W-DIM_W){1'b0}}, pallet_width};  dvs = bl; end
        endcase
      end
      PH_POSX, PH_POSY: begin
        dvd = pnum;
        dvs = {{(DIM_W-IDX_W-2){1'b0}}, nm1, 1'b0};
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  plgp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // A zero divisor means zero boxes on that axis, or a lone box at zero.
  assign q12 = (dvs == '0) ? '0 : quo[DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bl <= s_axis_tdata[DIM_W-1:0];
      bw <= s_axis_tdata[2*DIM_W-1:DIM_W];
      bh <= s_axis_tdata[3*DIM_W-1:2*DIM_W];
      ty <= s_axis_tdata[3*DIM_W+TYPE_W-1:3*DIM_W];
    end
    if (div_done) begin
      case (cmd.phase)
        PH_FIT: begin
          case (idx[1:0])
            FIT_NXO: nxo <= q12;
            FIT_NYO: nyo <= q12;
            FIT_NXR: nxr <= q12;
            default: nyr <= q12;
          endcase
        end
        PH_POSX: xpos[idx] <= q12;
        PH_POSY: ypos[idx] <= q12;
        default: ;
      endcase
    end
    if (cmd.mul_orig) co <= mul_a * mul_b;
    if (cmd.mul_rot)  cr <= mul_a * mul_b;
    if (cmd.choose) begin
      if (cr > co) begin
        rot <= 1'b1; nx <= nxr; ny <= nyr; sx <= bw; sy <= bl; cnt <= cr;
      end else begin
        rot <= 1'b0; nx <= nxo; ny <= nyo; sx <= bl; sy <= bw; cnt <= co;
      end
    end
  end

  // One shared 12 by 12 multiplier for both grid counts.
  assign mul_a = cmd.mul_rot ? nxr : nxo;
  assign mul_b = cmd.mul_rot ? nyr : nyo;

  // Loop counters: idx walks divisions, ex and ey walk the placements.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      ex  <= '0;
      ey  <= '0;
    end else begin
      if (cmd.clr_idx) begin
        idx <= '0;
        ex  <= '0;
        ey  <= '0;
      end else begin
        if (cmd.inc_idx) idx <= idx + IDX_W'(1);
        if (cmd.emit_load) begin
          if ({1'b0, ey} == nym1) begin
            ey <= '0;
            ex <= ex + IDX_W'(1);
          end else begin
            ey <= ey + IDX_W'(1);
          end
        end
      end
    end
  end

  assign empty_flag = (cnt == '0);
  assign ovf_flag   = (nx > DIM_W'(MAX_PER_AXIS)) || (ny > DIM_W'(MAX_PER_AXIS));
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign emit_last  = ({1'b0, ex} == nxm1) && ({1'b0, ey} == nym1);

  always_comb begin
    stat.div_done  = div_done;
    stat.empty     = empty_flag;
    stat.overflow  = ovf_flag;
    stat.out_free  = out_free;
    stat.emit_last = emit_last;
    case (cmd.phase)
      PH_POSX: stat.idx_last = ({1'b0, idx} == nxm1);
      PH_POSY: stat.idx_last = ({1'b0, idx} == nym1);
      default: stat.idx_last = (idx[1:0] == FIT_NYR);
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit_load || cmd.special_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load || cmd.special_load) begin
      o_size_x <= sx;
      o_size_y <= sy;
      o_size_z <= bh;
      o_type   <= ty;
      o_rot    <= rot;
      o_cnt    <= cnt;
    end
    if (cmd.emit_load) begin
      o_pos_x <= xpos[ex];
      o_pos_y <= ypos[ey];
      o_empty <= 1'b0;
      o_ovf   <= 1'b0;
      o_last  <= emit_last;
    end else if (cmd.special_load) begin
      o_pos_x <= '0;
      o_pos_y <= '0;
      o_empty <= empty_flag;
      o_ovf   <= !empty_flag;
      o_last  <= 1'b1;
    end
  end

  assign m_axis_tdata = {3'b000, o_cnt, o_rot, o_type, o_size_z, o_size_y, o_size_x,
                         o_pos_y, o_pos_x};
  assign m_axis_tuser = {o_ovf, o_empty};
  assign m_axis_tlast = o_last;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the pallet layer grid placer top level.
// Needs plgp_pkg and pallet_layer_grid_placer_top; drives both streams and
// the configuration channel, and predicts every placement internally.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plgp_pkg::*;

  // One placement as it leaves the block, unpacked from tdata, tuser and tlast.
  typedef struct {
    logic [DIM_W-1:0]   pos_x;
    logic [DIM_W-1:0]   pos_y;
    logic [DIM_W-1:0]   size_x;
    logic [DIM_W-1:0]   size_y;
    logic [DIM_W-1:0]   size_z;
    logic [TYPE_W-1:0]  box_type;
    logic               rotated;
    logic [COUNT_W-1:0] layer_count;
    logic               empty_res;
    logic               overflow;
    logic               last;
  } placement_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  reg_idx_t             cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  // Our own copy of the pallet footprint, updated when a write transaction
  // completes on the configuration channel.
  logic [DIM_W-1:0] pallet_len_mirror;
  logic [DIM_W-1:0] pallet_wid_mirror;

  // Placements still owed by the block, oldest first.
  placement_t pending_placements[$];

  int unsigned fail_count;
  int unsigned boxes_sent;
  int unsigned pallet_settings;
  int unsigned placements_seen;
  int unsigned specials_seen;

  // When set, neither side idles any more (the tail of the run).
  bit          calm;
  // Tracks the last value scheduled on s_axis_tvalid, so that a gap never
  // schedules a second assignment in the step where a transaction completed.
  bit          box_valid_mirror;
  int unsigned stall_left;

  pallet_layer_grid_placer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Layer prediction
  // ---------------------------------------------------------------------------

  // Boxes of one size along one pallet axis; a zero size fits nothing.
  function automatic int unsigned axis_fit(int unsigned extent, int unsigned size);
    if (size == 0) return 0;
    return extent / size;
  endfunction

  // Start of box i out of n along an axis: first flush with the near wall,
  // last flush with the far wall, the rest evenly spread, halves rounded up.
  function automatic logic [DIM_W-1:0] spread_start(int unsigned i, int unsigned n,
                                                    int unsigned d, int unsigned f);
    int unsigned num;
    int unsigned den;
    if (n <= 1 || f < d) return '0;
    num = 2 * i * (f - d) + (n - 1);
    den = 2 * (n - 1);
    return DIM_W'(num / den);
  endfunction

  // Appends one placement to the back of the owed list.
  function automatic void owe_placement(placement_t p);
    pending_placements = {pending_placements, p};
  endfunction

  // Works out the whole layer for one box type and queues its placements.
  function automatic void predict_layer(logic [DIM_W-1:0] len, logic [DIM_W-1:0] wid,
                                        logic [DIM_W-1:0] hgt, logic [TYPE_W-1:0] kind);
    int unsigned nx_orig;
    int unsigned ny_orig;
    int unsigned nx_rot;
    int unsigned ny_rot;
    int unsigned nx;
    int unsigned ny;
    int unsigned count_orig;
    int unsigned count_rot;
    placement_t  p;
    nx_orig    = axis_fit(pallet_len_mirror, len);
    ny_orig    = axis_fit(pallet_wid_mirror, wid);
    nx_rot     = axis_fit(pallet_len_mirror, wid);
    ny_rot     = axis_fit(pallet_wid_mirror, len);
    count_orig = nx_orig * ny_orig;
    count_rot  = nx_rot * ny_rot;

    p.size_z    = hgt;
    p.box_type  = kind;
    p.pos_x     = '0;
    p.pos_y     = '0;
    p.empty_res = 1'b0;
    p.overflow  = 1'b0;
    // The turned grid only wins when it strictly holds more boxes.
    if (count_rot > count_orig) begin
      p.rotated     = 1'b1;
      nx            = nx_rot;
      ny            = ny_rot;
      p.size_x      = wid;
      p.size_y      = len;
      p.layer_count = COUNT_W'(count_rot);
    end else begin
      p.rotated     = 1'b0;
      nx            = nx_orig;
      ny            = ny_orig;
      p.size_x      = len;
      p.size_y      = wid;
      p.layer_count = COUNT_W'(count_orig);
    end

    if (p.layer_count == 0 || nx > MAX_PER_AXIS || ny > MAX_PER_AXIS) begin
      p.empty_res = (p.layer_count == 0);
      p.overflow  = (p.layer_count != 0);
      p.last      = 1'b1;
      owe_placement(p);
      return;
    end

    for (int unsigned xi = 0; xi < nx; xi++) begin
      for (int unsigned yi = 0; yi < ny; yi++) begin
        p.pos_x = spread_start(xi, nx, p.size_x, pallet_len_mirror);
        p.pos_y = spread_start(yi, ny, p.size_y, pallet_wid_mirror);
        p.last  = (xi + 1 == nx) && (yi + 1 == ny);
        owe_placement(p);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the result checker
  // ---------------------------------------------------------------------------

  // Stalls come in bursts of random length; calm turns them off for good.
  always @(posedge clk) begin
    if (calm) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      stall_left = $urandom_range(10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [COUNT_W-1:0] want,
                             logic [COUNT_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      // Keep the log readable if the block goes badly wrong.
      if (fail_count <= 200)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Every output transaction is matched against the oldest owed placement.
  always @(posedge clk) begin : result_checker
    placement_t got;
    placement_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pos_x       = m_axis_tdata[11:0];
      got.pos_y       = m_axis_tdata[23:12];
      got.size_x      = m_axis_tdata[35:24];
      got.size_y      = m_axis_tdata[47:36];
      got.size_z      = m_axis_tdata[59:48];
      got.box_type    = m_axis_tdata[75:60];
      got.rotated     = m_axis_tdata[76];
      got.layer_count = m_axis_tdata[100:77];
      got.empty_res   = m_axis_tuser[0];
      got.overflow    = m_axis_tuser[1];
      got.last        = m_axis_tlast;
      placements_seen++;
      if (got.empty_res || got.overflow) specials_seen++;
      if (pending_placements.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected placement, expected none, actual x %0d y %0d type %0d",
                 $time, got.pos_x, got.pos_y, got.box_type);
      end else begin
        want = pending_placements.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("size_x", want.size_x, got.size_x);
        check_field("size_y", want.size_y, got.size_y);
        check_field("size_z", want.size_z, got.size_z);
        check_field("box_type", want.box_type, got.box_type);
        check_field("rotated", want.rotated, got.rotated);
        check_field("layer_count", want.layer_count, got.layer_count);
        check_field("empty_res", want.empty_res, got.empty_res);
        check_field("overflow", want.overflow, got.overflow);
        check_field("last", want.last, got.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers
  // ---------------------------------------------------------------------------

  // Offers one box type and returns at the edge where the transaction
  // completes, leaving tvalid high so that the next box can follow at once.
  task automatic send_box(logic [DIM_W-1:0] len, logic [DIM_W-1:0] wid,
                          logic [DIM_W-1:0] hgt, logic [TYPE_W-1:0] kind);
    if (!calm && $urandom_range(3) == 0) begin
      if (box_valid_mirror) s_axis_tvalid <= 1'b0;
      box_valid_mirror = 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
    s_axis_tvalid    <= 1'b1;
    box_valid_mirror = 1'b1;
    s_axis_tdata     <= {4'b0, kind, hgt, wid, len};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_layer(len, wid, hgt, kind);
    boxes_sent++;
  endtask

  task automatic lower_input();
    if (box_valid_mirror) s_axis_tvalid <= 1'b0;
    box_valid_mirror = 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_layers_done();
    while (pending_placements.size() != 0) @(posedge clk);
  endtask

  // Changes the footprint while the block is idle: every owed placement
  // must have arrived first. Both registers go in back to back.
  task automatic set_pallet(logic [DIM_W-1:0] len, logic [DIM_W-1:0] wid);
    lower_input();
    wait_layers_done();
    cfg_valid <= 1'b1;
    cfg_index <= REG_PALLET_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pallet_len_mirror = len;
    cfg_index <= REG_PALLET_WIDTH;
    cfg_data  <= wid;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pallet_wid_mirror = wid;
    cfg_valid <= 1'b0;
    pallet_settings++;
  endtask

  // A box side that aims at one to MAX_PER_AXIS boxes on an axis; the fallbacks may miss that range.
  function automatic logic [DIM_W-1:0] side_for_grid(logic [DIM_W-1:0] extent);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    if (extent == 0) return DIM_W'($urandom_range(4095, 1));
    n  = $urandom_range(MAX_PER_AXIS, 1);
    hi = extent / n;
    lo = extent / (n + 1) + 1;
    if (hi < lo || hi == 0) return DIM_W'($urandom_range(extent, 1));
    return DIM_W'($urandom_range(hi, lo));
  endfunction

  // Mostly boxes that tile the footprint into a grid the block will place,
  // the rest raw noise, grids that are too fine, zero sides and oversize boxes.
  task automatic send_random_box();
    logic [DIM_W-1:0] len;
    logic [DIM_W-1:0] wid;
    logic [DIM_W-1:0] swap;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = side_for_grid(pallet_len_mirror);
      wid = side_for_grid(pallet_wid_mirror);
      if ($urandom_range(3) == 0) begin
        swap = len;
        len  = wid;
        wid  = swap;
      end
    end else if (pick < 85) begin
      len = DIM_W'($urandom_range(4095));
      wid = DIM_W'($urandom_range(4095));
    end else begin
      case ($urandom_range(2))
        0: begin
          // Finer than the axis limit allows on at least one side.
          len = DIM_W'($urandom_range(pallet_len_mirror / 9 > 1 ? pallet_len_mirror / 9 : 1, 1));
          wid = DIM_W'($urandom_range(pallet_wid_mirror / 9 > 1 ? pallet_wid_mirror / 9 : 1, 1));
        end
        1: begin
          len = $urandom_range(1) ? '0 : DIM_W'($urandom_range(4095));
          wid = (len != 0) ? '0 : DIM_W'($urandom_range(4095));
        end
        default: begin
          len = DIM_W'($urandom_range(4095, pallet_len_mirror));
          wid = DIM_W'($urandom_range(4095, pallet_wid_mirror));
        end
      endcase
    end
    send_box(len, wid, DIM_W'($urandom_range(4095)), TYPE_W'($urandom_range(65535)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset footprint of 1200 by 800: plain grids, the turned grid winning and
  // tying, a single box, the full 8 by 8 layer, the rounding of halves,
  // too fine a grid, nothing fitting and zero box sides.
  task automatic test_reset_footprint();
    send_box(12'd400, 12'd400, 12'd300, 16'h0001);
    send_box(12'd700, 12'd350, 12'd250, 16'h0002);
    send_box(12'd500, 12'd300, 12'd200, 16'h0003);
    send_box(12'd1200, 12'd800, 12'd1, 16'h0000);
    send_box(12'd150, 12'd100, 12'd100, 16'h1234);
    send_box(12'd399, 12'd399, 12'd399, 16'h8000);
    send_box(12'd100, 12'd100, 12'd50, 16'h00ff);
    send_box(12'd1, 12'd1, 12'd2, 16'h7fff);
    send_box(12'd1300, 12'd100, 12'd10, 16'h0f0f);
    send_box(12'd0, 12'd0, 12'd0, 16'h0000);
    send_box(12'd0, 12'd400, 12'd800, 16'h5555);
    send_box(12'd400, 12'd0, 12'd800, 16'haaaa);
    send_box(12'd4095, 12'd4095, 12'd4095, 16'hffff);
    lower_input();
  endtask

  // Footprints at the ends of the register range, including a zero side.
  task automatic test_extreme_footprints();
    set_pallet(12'd4095, 12'd4095);
    send_box(12'd4095, 12'd4095, 12'd4095, 16'hffff);
    send_box(12'd511, 12'd511, 12'd2048, 16'h4242);
    send_box(12'd455, 12'd600, 12'd7, 16'h0100);
    send_box(12'd1, 12'd1, 12'd1, 16'h0001);
    set_pallet(12'd1, 12'd1);
    send_box(12'd1, 12'd1, 12'd4095, 16'hbeef);
    send_box(12'd2, 12'd1, 12'd33, 16'h0002);
    set_pallet(12'd4095, 12'd0);
    send_box(12'd100, 12'd100, 12'd100, 16'h0003);
    set_pallet(12'd0, 12'd2047);
    send_box(12'd100, 12'd100, 12'd100, 16'h0004);
    lower_input();
  endtask

  // Random box types over several random footprints; the last phase runs
  // without any idling on either side.
  task automatic test_random_layers();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 2)
        set_pallet(12'd4095, DIM_W'($urandom_range(200, 8)));
      else
        set_pallet(DIM_W'($urandom_range(4095, 64)), DIM_W'($urandom_range(4095, 64)));
      if (phase == 4) calm = 1'b1;
      repeat (30) send_random_box();
      lower_input();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst               = 1'b1;
    cfg_valid         = 1'b0;
    cfg_index         = REG_PALLET_LENGTH;
    cfg_data          = '0;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    m_axis_tready     = 1'b1;
    box_valid_mirror  = 1'b0;
    calm              = 1'b0;
    stall_left        = 0;
    fail_count        = 0;
    boxes_sent        = 0;
    pallet_settings   = 1;
    placements_seen   = 0;
    specials_seen     = 0;
    pallet_len_mirror = PALLET_LENGTH_RST;
    pallet_wid_mirror = PALLET_WIDTH_RST;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_footprint();
    test_extreme_footprints();
    test_random_layers();

    // Let the last layer drain, then give the block time to show any
    // placement it should not produce.
    wait_layers_done();
    repeat (300) @(posedge clk);

    $display("Run covered %0d box types over %0d pallet footprints,", boxes_sent,
             pallet_settings);
    $display("with %0d placements checked, %0d of them empty or overflow results.",
             placements_seen, specials_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with every output stalled.
  initial begin
    #10_000_000;
    $display("Timeout with %0d placements still owed.", pending_placements.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
hdl/plgp_pkg.sv
hdl/plgp_div.sv
hdl/plgp_ctrl.sv
hdl/plgp_datapath.sv
hdl/pallet_layer_grid_placer_top.sv
tb/sv/testbench.sv
